// File: design/lp2c_pkg.sv
package lp2c_pkg;

  // Default configuration of the converter.
  localparam int unsigned DIST_BITS_DEF       = 20;
  localparam int unsigned ROTATION_STAGES_DEF = 18;

  // Fixed-point formats.
  localparam int unsigned ANGLE_BITS  = 16;
  localparam int unsigned PHASE_BITS  = 32;   // 2^32 units per full turn
  localparam int unsigned FRAC_BITS   = 24;   // fraction bits of the rotation datapath
  localparam int unsigned GAIN_BITS   = 30;
  localparam int unsigned GAIN_SHIFT  = GAIN_BITS - FRAC_BITS;
  localparam int unsigned ATAN_ENTRIES = 24;

  // Rotator gain correction, 0.60725293500888 in Q30.
  localparam logic [GAIN_BITS-1:0] GAIN_Q30 = 30'd652032875;

  // Arctangent of 2^-i, 2^32 units per full turn.
  localparam logic [PHASE_BITS-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Quadrant the residual rotation is referred to.
  typedef enum logic [1:0] {
    QUAD_POS_X = 2'd0,
    QUAD_POS_Y = 2'd1,
    QUAD_NEG_X = 2'd2,
    QUAD_NEG_Y = 2'd3
  } quad_e;

  // Side information that travels down the pipeline with each point.
  typedef struct packed {
    quad_e quad;
    logic  point;
    logic  scan_end;
  } tag_t;

endpackage

// File: design/lp2c_rot_stage.sv
module lp2c_rot_stage #(
  parameter int unsigned DW    = lp2c_pkg::DIST_BITS_DEF + lp2c_pkg::FRAC_BITS + 2,
  parameter int unsigned STAGE = 0
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  logic signed [DW-1:0]                    x_i,
  input  logic signed [DW-1:0]                    y_i,
  input  logic signed [lp2c_pkg::PHASE_BITS-1:0]  z_i,
  input  lp2c_pkg::tag_t                          tag_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output logic signed [DW-1:0]                    x_o,
  output logic signed [DW-1:0]                    y_o,
  output logic signed [lp2c_pkg::PHASE_BITS-1:0]  z_o,
  output lp2c_pkg::tag_t                          tag_o
);

  localparam logic signed [lp2c_pkg::PHASE_BITS-1:0] ANGLE = lp2c_pkg::ATAN_TAB[STAGE];

  logic                                   valid_q;
  logic signed [DW-1:0]                   x_q, x_d;
  logic signed [DW-1:0]                   y_q, y_d;
  logic signed [lp2c_pkg::PHASE_BITS-1:0] z_q, z_d;
  lp2c_pkg::tag_t                         tag_q;
  logic signed [DW-1:0]                   dx, dy;

  assign ready_o = !valid_q || ready_i;

  // One micro-rotation; the residual angle's sign picks the direction.
  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (!z_i[lp2c_pkg::PHASE_BITS-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ANGLE;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ANGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      tag_q <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign tag_o   = tag_q;

endmodule

// File: design/lidar_polar_to_cartesian.sv
// Pipeline registers in order: input stage, gain stage, one per micro-rotation, quadrant stage, output stage.
// Throughput: one point per cycle while the output is not stalled; every stage holds its own valid bit and register,
// so a stalled output backs up stage by stage and bubbles are squeezed out.
// Points with zero distance and no end-of-scan mark produce no result.
// Reset (rst_ni, asynchronous, active low) clears all valid bits; data registers
// are not reset.
module lidar_polar_to_cartesian #(
  parameter int unsigned DIST_BITS       = lp2c_pkg::DIST_BITS_DEF,
  parameter int unsigned ROTATION_STAGES = lp2c_pkg::ROTATION_STAGES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Measurement channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [lp2c_pkg::ANGLE_BITS-1:0]      angle_code_i,
  input  logic [DIST_BITS-1:0]                 distance_quarter_mm_i,
  input  logic                                 scan_end_i,
  // Cartesian point channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [DIST_BITS:0]            x_quarter_mm_o,
  output logic signed [DIST_BITS:0]            y_quarter_mm_o,
  output logic                                 point_valid_o,
  output logic                                 scan_end_out_o
);

  // The rotation datapath carries the distance in Q24 with two bits of headroom
  // for the growth of the micro-rotations and for the quadrant negation.
  localparam int unsigned FB   = lp2c_pkg::FRAC_BITS;
  localparam int unsigned PB   = lp2c_pkg::PHASE_BITS;
  localparam int unsigned AB   = lp2c_pkg::ANGLE_BITS;
  localparam int unsigned W    = DIST_BITS + FB + 2;
  localparam int unsigned MW   = DIST_BITS + lp2c_pkg::GAIN_BITS;
  localparam int unsigned RW   = W - FB;
  localparam int unsigned NSTG = (ROTATION_STAGES < lp2c_pkg::ATAN_ENTRIES) ?
                                 ROTATION_STAGES : lp2c_pkg::ATAN_ENTRIES;

  localparam logic signed [W-1:0]  HALF_LSB = W'(1) << (FB - 1);
  localparam logic signed [RW-1:0] MAX_MAG  = (RW'(1) << DIST_BITS) - RW'(1);
  localparam logic signed [RW-1:0] MIN_MAG  = -MAX_MAG;

  // ---------------------------------------------------------------------------
  // Input stage: angle reduction. The code is split into a quadrant and a signed
  // residual within plus or minus one eighth of a turn; the residual becomes the
  // starting phase of the rotator. Points with no return and no scan mark are
  // dropped here, so they never occupy a pipeline slot.
  // ---------------------------------------------------------------------------
  logic                   s0_valid_q;
  logic [DIST_BITS-1:0]   s0_dist_q;
  logic signed [PB-1:0]   s0_z_q;
  lp2c_pkg::tag_t         s0_tag_q;
  logic                   s0_ready;
  logic                   s0_keep;
  logic [AB-1:0]          angle_bias;
  logic [AB-1:0]          angle_res;
  lp2c_pkg::tag_t         in_tag;

  logic                   s1_valid_q;
  logic signed [W-1:0]    s1_x_q;
  logic signed [PB-1:0]   s1_z_q;
  lp2c_pkg::tag_t         s1_tag_q;
  logic                   s1_ready;
  logic [MW-1:0]          gain_prod;

  // Rotator chain. Index 0 is the gain stage output, index i+1 the output of
  // micro-rotation i.
  logic                 rot_valid [NSTG+1];
  logic                 rot_ready [NSTG+1];
  logic signed [W-1:0]  rot_x     [NSTG+1];
  logic signed [W-1:0]  rot_y     [NSTG+1];
  logic signed [PB-1:0] rot_z     [NSTG+1];
  lp2c_pkg::tag_t       rot_tag   [NSTG+1];

  always_comb begin
    angle_bias        = angle_code_i + AB'(16'd8192);
    in_tag.quad       = lp2c_pkg::quad_e'(angle_bias[AB-1:AB-2]);
    in_tag.point      = (distance_quarter_mm_i != '0);
    in_tag.scan_end   = scan_end_i;
    angle_res         = angle_code_i - {angle_bias[AB-1:AB-2], (AB-2)'(0)};
    s0_keep           = in_tag.point || scan_end_i;
  end

  assign s0_ready   = !s0_valid_q || s1_ready;
  assign in_ready_o = s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_q <= in_valid_i && s0_keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s0_ready) begin
      s0_dist_q <= distance_quarter_mm_i;
      s0_z_q    <= {angle_res, (PB-AB)'(0)};
      s0_tag_q  <= in_tag;
    end
  end

  // ---------------------------------------------------------------------------
  // Gain stage: the start vector is the distance pre-scaled by the inverse
  // rotator gain, so the micro-rotations end at the true length. A distance of
  // zero gives a zero vector, which the rotator leaves at zero.
  // ---------------------------------------------------------------------------
  assign gain_prod = MW'(s0_dist_q) * MW'(lp2c_pkg::GAIN_Q30);
  assign s1_ready  = !s1_valid_q || rot_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_valid_q && s1_ready) begin
      s1_x_q   <= {2'b00, gain_prod[MW-1:lp2c_pkg::GAIN_SHIFT]};
      s1_z_q   <= s0_z_q;
      s1_tag_q <= s0_tag_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Rotator: one registered micro-rotation per stage.
  // ---------------------------------------------------------------------------
  assign rot_valid[0] = s1_valid_q;
  assign rot_x[0]     = s1_x_q;
  assign rot_y[0]     = '0;
  assign rot_z[0]     = s1_z_q;
  assign rot_tag[0]   = s1_tag_q;

  for (genvar i = 0; i < NSTG; i++) begin : g_rot
    lp2c_rot_stage #(
      .DW    (W),
      .STAGE (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (rot_valid[i]),
      .ready_o (rot_ready[i]),
      .x_i     (rot_x[i]),
      .y_i     (rot_y[i]),
      .z_i     (rot_z[i]),
      .tag_i   (rot_tag[i]),
      .valid_o (rot_valid[i+1]),
      .ready_i (rot_ready[i+1]),
      .x_o     (rot_x[i+1]),
      .y_o     (rot_y[i+1]),
      .z_o     (rot_z[i+1]),
      .tag_o   (rot_tag[i+1])
    );
  end

  // The final residual phase is not needed once the rotation is done.
  logic signed [PB-1:0] rot_z_last;
  assign rot_z_last = rot_z[NSTG];

  // ---------------------------------------------------------------------------
  // Quadrant stage: the whole quarter turns taken off at the input are applied
  // exactly by swapping and negating the rotated vector.
  // ---------------------------------------------------------------------------
  logic                 sq_valid_q;
  logic signed [W-1:0]  sq_x_q, sq_x_d;
  logic signed [W-1:0]  sq_y_q, sq_y_d;
  lp2c_pkg::tag_t       sq_tag_q;
  logic                 sq_ready;
  logic                 out_ready;

  always_comb begin
    case (rot_tag[NSTG].quad)
      lp2c_pkg::QUAD_POS_X: begin
        sq_x_d = rot_x[NSTG];
        sq_y_d = rot_y[NSTG];
      end
      lp2c_pkg::QUAD_POS_Y: begin
        sq_x_d = -rot_y[NSTG];
        sq_y_d = rot_x[NSTG];
      end
      lp2c_pkg::QUAD_NEG_X: begin
        sq_x_d = -rot_x[NSTG];
        sq_y_d = -rot_y[NSTG];
      end
      lp2c_pkg::QUAD_NEG_Y: begin
        sq_x_d = rot_y[NSTG];
        sq_y_d = -rot_x[NSTG];
      end
      default: begin
        sq_x_d = rot_x[NSTG];
        sq_y_d = rot_y[NSTG];
      end
    endcase
  end

  assign rot_ready[NSTG] = sq_ready;
  assign sq_ready        = !sq_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else if (sq_ready) begin
      sq_valid_q <= rot_valid[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rot_valid[NSTG] && sq_ready && (rot_z_last == rot_z[NSTG])) begin
      sq_x_q   <= sq_x_d;
      sq_y_q   <= sq_y_d;
      sq_tag_q <= rot_tag[NSTG];
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: round to nearest with ties toward plus infinity, then
  // saturate to the symmetric range of the result fields. This register is the
  // output register of the block.
  // ---------------------------------------------------------------------------
  logic                     out_valid_q;
  logic signed [DIST_BITS:0] out_x_q, out_x_d;
  logic signed [DIST_BITS:0] out_y_q, out_y_d;
  lp2c_pkg::tag_t           out_tag_q;
  logic signed [W-1:0]      rnd_x_sum, rnd_y_sum;
  logic signed [RW-1:0]     rnd_x, rnd_y;

  always_comb begin
    rnd_x_sum = sq_x_q + HALF_LSB;
    rnd_y_sum = sq_y_q + HALF_LSB;
    rnd_x     = rnd_x_sum[W-1:FB];
    rnd_y     = rnd_y_sum[W-1:FB];
    if (rnd_x > MAX_MAG) begin
      out_x_d = MAX_MAG[DIST_BITS:0];
    end else if (rnd_x < MIN_MAG) begin
      out_x_d = MIN_MAG[DIST_BITS:0];
    end else begin
      out_x_d = rnd_x[DIST_BITS:0];
    end
    if (rnd_y > MAX_MAG) begin
      out_y_d = MAX_MAG[DIST_BITS:0];
    end else if (rnd_y < MIN_MAG) begin
      out_y_d = MIN_MAG[DIST_BITS:0];
    end else begin
      out_y_d = rnd_y[DIST_BITS:0];
    end
  end

  assign out_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_valid_q && out_ready) begin
      out_x_q   <= out_x_d;
      out_y_q   <= out_y_d;
      out_tag_q <= sq_tag_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign x_quarter_mm_o = out_x_q;
  assign y_quarter_mm_o = out_y_q;
  assign point_valid_o  = out_tag_q.point;
  assign scan_end_out_o = out_tag_q.scan_end;

endmodule
